@@ rtl/core/segmented_extent_remap_core_defines.svh @@
// ----------------------------------------------------------------------------
// Segmented extent remap core: assertion macros
// Shared property wrappers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_EXTENT_REMAP_CORE_DEFINES_SVH
`define SEGMENTED_EXTENT_REMAP_CORE_DEFINES_SVH

// check a property outside reset
`define SXR_CHECK(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("segmented_extent_remap_core: property failed");

// check a property at every edge, reset included
`define SXR_CHECK_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("segmented_extent_remap_core: property failed");

`endif

@@ rtl/core/sxr_pkg.sv @@
// ----------------------------------------------------------------------------
// sxr_pkg
// Types and constants shared by the segmented extent remap core.
// ----------------------------------------------------------------------------
package sxr_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int IDX_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BITS  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 4'd3;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_RANGE    = 2'd1,
        STAT_PAST_END = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_XLATE,
        CMD_RANGE_ERR
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_EVAL,
        BK_SEND
    } bk_state_t;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_CHECK,
        PH_EMIT
    } phase_t;

    typedef struct packed {
        logic [63:0] base_offset;
        logic [5:0]  sel_width;
        logic [4:0]  segment_count;
        logic [6:0]  entry_limit;
    } cfg_t;

    // write: addr, a = vstart, b = vend, c = pstart
    // translate: addr = first entry, total, a = offset, len
    typedef struct packed {
        cmd_kind_t        kind;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] total;
        logic [63:0]      a;
        logic [63:0]      b;
        logic [63:0]      c;
        logic [31:0]      len;
    } cmd_t;

endpackage

@@ rtl/core/segmented_extent_remap_core.sv @@
// ----------------------------------------------------------------------------
// segmented_extent_remap_core
// Extent map translation: loads map entries into segments and splits read
// requests into physical chunks.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_* writes the base offset, select width, segment count and entry
//   limit by index; write only while idle. s_* carries loads (action 0) and
//   translations (action 1); m_* returns chunks, last_chunk on the final one.
//   A load gives no result; an in-order load within the limits goes into the
//   queue at one per cycle while the queue has room, and the back part writes it to the tables.
//   A translation holds the back part while it searches the segment's entries
//   up to the hit, crosses the spanned entries once to check the span and
//   once to emit, and sends each chunk: each entry visit is a read state
//   plus an evaluate state, and each chunk passes through a send state; a
//   chunk shows on m_* the cycle after its send. An error result is sent
//   right after the search or the span check, or from idle on a bad select.
//   Requests run one at a time in the back part; the two-entry queue lets
//   the front keep accepting meanwhile.
//   Reset clears the segment list, loaded count and config registers (select
//   width resets to 1); the tables need no clearing pass. A stalled m_ready
//   holds the result register and, once the queue fills, s_ready.
// ----------------------------------------------------------------------------
`include "segmented_extent_remap_core_defines.svh"

module segmented_extent_remap_core import sxr_pkg::*; #(
    parameter int MAX_ENTRIES  = 64,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [5:0]           s_entry_index,
    input  logic [63:0]          s_entry_virtual_start,
    input  logic [63:0]          s_entry_physical_start,
    input  logic [63:0]          s_entry_size,
    input  logic [63:0]          s_request_offset,
    input  logic [31:0]          s_request_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_chunk_physical,
    output logic [31:0]          m_chunk_length,
    output logic [1:0]           m_status,
    output logic                 m_last_chunk
);

    cfg_t cfg_reg, cfg_next;
    logic q_push, q_full, q_pop, q_valid;
    cmd_t q_in, q_head;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_BASE_OFFSET:   cfg_next.base_offset   = cfg_data;
                CFG_SEGMENT_BITS:  cfg_next.sel_width     = cfg_data[5:0];
                CFG_SEGMENT_COUNT: cfg_next.segment_count = cfg_data[4:0];
                CFG_ENTRY_COUNT:   cfg_next.entry_limit   = cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_offset   <= 64'd0;
            cfg_reg.sel_width     <= 6'd1;
            cfg_reg.segment_count <= 5'd0;
            cfg_reg.entry_limit   <= 7'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sxr_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg                   (cfg_reg),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_action              (s_action),
        .s_entry_index         (s_entry_index),
        .s_entry_virtual_start (s_entry_virtual_start),
        .s_entry_physical_start(s_entry_physical_start),
        .s_entry_size          (s_entry_size),
        .s_request_offset      (s_request_offset),
        .s_request_length      (s_request_length),
        .q_push                (q_push),
        .q_data                (q_in),
        .q_full                (q_full)
    );

    sxr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_data (q_head)
    );

    sxr_back #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .base_offset     (cfg_reg.base_offset),
        .q_valid         (q_valid),
        .q_data          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_chunk_physical(m_chunk_physical),
        .m_chunk_length  (m_chunk_length),
        .m_status        (m_status),
        .m_last_chunk    (m_last_chunk)
    );

    `SXR_CHECK(a_err_last, m_valid && m_status != STAT_OK |-> m_last_chunk && m_chunk_length == '0)
    `SXR_CHECK(a_mid_chunk, m_valid && !m_last_chunk |-> m_chunk_length != '0 && m_status == STAT_OK)
    `SXR_CHECK_ALWAYS(a_rst_cfg, !aresetn |=> cfg_reg.sel_width == 6'd1 && cfg_reg.entry_limit == '0)

endmodule

@@ rtl/core/sxr_queue.sv @@
// ----------------------------------------------------------------------------
// sxr_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module sxr_queue import sxr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_data
);

    cmd_t        slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/sxr_front.sv @@
// ----------------------------------------------------------------------------
// sxr_front
// Accepts requests, builds the segment list and classifies translations.
// ----------------------------------------------------------------------------
module sxr_front import sxr_pkg::*; #(
    parameter int MAX_ENTRIES  = 64,
    parameter int MAX_SEGMENTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_action,
    input  logic [5:0]  s_entry_index,
    input  logic [63:0] s_entry_virtual_start,
    input  logic [63:0] s_entry_physical_start,
    input  logic [63:0] s_entry_size,
    input  logic [63:0] s_request_offset,
    input  logic [31:0] s_request_length,
    output logic        q_push,
    output cmd_t        q_data,
    input  logic        q_full
);

    localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int SCW = $clog2(MAX_SEGMENTS + 1);

    logic [CW-1:0]  loaded_reg, loaded_next;
    logic [SCW-1:0] built_reg, built_next;
    logic [63:0]    prev_end_reg, prev_end_next;
    logic           stopped_reg, stopped_next;
    logic [EW-1:0]  seg_first_reg [MAX_SEGMENTS];
    logic [CW-1:0]  seg_total_reg [MAX_SEGMENTS];

    logic           accept, load_ok, join_seg, seg_full, load_take;
    logic [63:0]    vend, seg_sel64;
    logic [31:0]    seg_sel;
    logic           seg_ok;
    logic [SIW-1:0] seg_wr_idx, seg_rd_idx;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        vend      = s_entry_virtual_start + s_entry_size;
        load_ok   = !stopped_reg && (32'(s_entry_index) == 32'(loaded_reg))
                    && (32'(loaded_reg) < 32'(cfg.entry_limit))
                    && (32'(loaded_reg) < MAX_ENTRIES);
        join_seg  = (built_reg != '0) && (s_entry_virtual_start == prev_end_reg);
        seg_full  = (32'(built_reg) >= 32'(cfg.segment_count))
                    || (32'(built_reg) >= MAX_SEGMENTS);
        load_take = accept && !s_action && load_ok && (join_seg || !seg_full);
        seg_wr_idx = SIW'(built_reg - SCW'(join_seg));

        if (cfg.sel_width == 6'd0) begin
            seg_sel64 = 64'd0;
        end else begin
            seg_sel64 = s_request_offset >> (7'd64 - {1'b0, cfg.sel_width});
        end
        seg_sel    = seg_sel64[31:0];
        seg_ok     = (seg_sel < 32'(cfg.segment_count)) && (seg_sel < 32'(built_reg))
                     && (seg_sel < MAX_SEGMENTS);
        seg_rd_idx = SIW'(seg_sel);

        q_data = '0;
        if (s_action) begin
            q_data.kind  = seg_ok ? CMD_XLATE : CMD_RANGE_ERR;
            q_data.addr  = IDX_W'(seg_first_reg[seg_rd_idx]);
            q_data.total = IDX_W'(seg_total_reg[seg_rd_idx]);
            q_data.a     = s_request_offset;
            q_data.len   = s_request_length;
        end else begin
            q_data.kind = CMD_WRITE;
            q_data.addr = IDX_W'(loaded_reg);
            q_data.a    = s_entry_virtual_start;
            q_data.b    = vend;
            q_data.c    = s_entry_physical_start;
        end
        q_push = (accept && s_action) || load_take;

        loaded_next   = loaded_reg;
        built_next    = built_reg;
        prev_end_next = prev_end_reg;
        stopped_next  = stopped_reg;
        if (accept && !s_action && load_ok && !join_seg && seg_full) begin
            stopped_next = 1'b1;
        end
        if (load_take) begin
            loaded_next   = loaded_reg + CW'(1);
            prev_end_next = vend;
            if (!join_seg) begin
                built_next = built_reg + SCW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg   <= '0;
            built_reg    <= '0;
            prev_end_reg <= '0;
            stopped_reg  <= 1'b0;
        end else begin
            loaded_reg   <= loaded_next;
            built_reg    <= built_next;
            prev_end_reg <= prev_end_next;
            stopped_reg  <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_take) begin
            if (!join_seg) begin
                seg_first_reg[seg_wr_idx] <= EW'(loaded_reg);
                seg_total_reg[seg_wr_idx] <= CW'(1);
            end else begin
                seg_total_reg[seg_wr_idx] <= seg_total_reg[seg_wr_idx] + CW'(1);
            end
        end
    end

endmodule

@@ rtl/core/sxr_back.sv @@
// ----------------------------------------------------------------------------
// sxr_back
// Holds the entry tables, walks a segment and emits the physical chunks.
// ----------------------------------------------------------------------------
module sxr_back import sxr_pkg::*; #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] base_offset,
    input  logic        q_valid,
    input  cmd_t        q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_chunk_physical,
    output logic [31:0] m_chunk_length,
    output logic [1:0]  m_status,
    output logic        m_last_chunk
);

    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [63:0] vstart_mem [MAX_ENTRIES];
    logic [63:0] vend_mem   [MAX_ENTRIES];
    logic [63:0] pstart_mem [MAX_ENTRIES];
    logic [63:0] rd_vstart, rd_vend, rd_pstart;

    bk_state_t   state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [EW-1:0] first_reg, first_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] i0_reg, i0_next;
    logic [63:0] off_reg, off_next;
    logic [31:0] len_reg, len_next;
    logic [63:0] pos_reg, pos_next;
    logic [31:0] rem_reg, rem_next;
    logic [63:0] pbase_reg, pbase_next;
    logic [63:0] delta_reg, delta_next;
    logic [31:0] rlen_reg, rlen_next;
    status_t     rstat_reg, rstat_next;
    logic        rlast_reg, rlast_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_phys_reg;
    logic [31:0] m_len_reg;
    status_t     m_stat_reg;
    logic        m_last_reg;

    logic          mem_we, out_load, hit;
    logic [EW-1:0] rd_addr, wr_addr;
    logic [63:0]   span;
    logic [31:0]   chunk;
    logic [CW-1:0] idx_inc;

    assign rd_addr = EW'(32'(first_reg) + 32'(idx_reg));
    assign wr_addr = EW'(q_data.addr);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            vstart_mem[wr_addr] <= q_data.a;
            vend_mem[wr_addr]   <= q_data.b;
            pstart_mem[wr_addr] <= q_data.c;
        end
        rd_vstart <= vstart_mem[rd_addr];
        rd_vend   <= vend_mem[rd_addr];
        rd_pstart <= pstart_mem[rd_addr];
    end

    always_comb begin
        span    = rd_vend - pos_reg;
        chunk   = (span < {32'd0, rem_reg}) ? span[31:0] : rem_reg;
        hit     = rd_vend > off_reg;
        idx_inc = idx_reg + CW'(1);

        state_next = state_reg;
        phase_next = phase_reg;
        first_next = first_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        i0_next    = i0_reg;
        off_next   = off_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        rem_next   = rem_reg;
        pbase_next = pbase_reg;
        delta_next = delta_reg;
        rlen_next  = rlen_reg;
        rstat_next = rstat_reg;
        rlast_next = rlast_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    case (q_data.kind)
                        CMD_WRITE: begin
                            mem_we = 1'b1;
                        end
                        CMD_XLATE: begin
                            first_next = EW'(q_data.addr);
                            total_next = CW'(q_data.total);
                            off_next   = q_data.a;
                            len_next   = q_data.len;
                            idx_next   = '0;
                            phase_next = PH_SEARCH;
                            state_next = BK_READ;
                        end
                        default: begin
                            pbase_next = '0;
                            delta_next = '0;
                            rlen_next  = '0;
                            rstat_next = STAT_RANGE;
                            rlast_next = 1'b1;
                            state_next = BK_SEND;
                        end
                    endcase
                end
            end
            BK_READ: begin
                state_next = BK_EVAL;
            end
            BK_EVAL: begin
                case (phase_reg)
                    PH_SEARCH: begin
                        if (hit && len_reg == 32'd0) begin
                            pbase_next = rd_pstart + base_offset;
                            delta_next = off_reg - rd_vstart;
                            rlen_next  = '0;
                            rstat_next = STAT_OK;
                            rlast_next = 1'b1;
                            state_next = BK_SEND;
                        end else if (hit) begin
                            phase_next = PH_CHECK;
                            i0_next    = idx_reg;
                            pos_next   = off_reg;
                            rem_next   = len_reg;
                            state_next = BK_READ;
                        end else if (idx_inc >= total_reg) begin
                            pbase_next = '0;
                            delta_next = '0;
                            rlen_next  = '0;
                            rstat_next = STAT_RANGE;
                            rlast_next = 1'b1;
                            state_next = BK_SEND;
                        end else begin
                            idx_next   = idx_inc;
                            state_next = BK_READ;
                        end
                    end
                    PH_CHECK: begin
                        pos_next = pos_reg + 64'(chunk);
                        rem_next = rem_reg - chunk;
                        idx_next = idx_inc;
                        if (rem_reg == chunk) begin
                            phase_next = PH_EMIT;
                            idx_next   = i0_reg;
                            pos_next   = off_reg;
                            rem_next   = len_reg;
                            state_next = BK_READ;
                        end else if (idx_inc >= total_reg) begin
                            pbase_next = '0;
                            delta_next = '0;
                            rlen_next  = '0;
                            rstat_next = STAT_PAST_END;
                            rlast_next = 1'b1;
                            state_next = BK_SEND;
                        end else begin
                            state_next = BK_READ;
                        end
                    end
                    default: begin
                        pos_next = pos_reg + 64'(chunk);
                        rem_next = rem_reg - chunk;
                        idx_next = idx_inc;
                        if (chunk != 32'd0) begin
                            pbase_next = rd_pstart + base_offset;
                            delta_next = pos_reg - rd_vstart;
                            rlen_next  = chunk;
                            rstat_next = STAT_OK;
                            rlast_next = (rem_reg == chunk);
                            state_next = BK_SEND;
                        end else begin
                            state_next = BK_READ;
                        end
                    end
                endcase
            end
            BK_SEND: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = rlast_reg ? BK_IDLE : BK_READ;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            phase_reg   <= PH_SEARCH;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        total_reg <= total_next;
        idx_reg   <= idx_next;
        i0_reg    <= i0_next;
        off_reg   <= off_next;
        len_reg   <= len_next;
        pos_reg   <= pos_next;
        rem_reg   <= rem_next;
        pbase_reg <= pbase_next;
        delta_reg <= delta_next;
        rlen_reg  <= rlen_next;
        rstat_reg <= rstat_next;
        rlast_reg <= rlast_next;
        if (out_load) begin
            m_phys_reg <= pbase_reg + delta_reg;
            m_len_reg  <= rlen_reg;
            m_stat_reg <= rstat_reg;
            m_last_reg <= rlast_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_chunk_physical = m_phys_reg;
    assign m_chunk_length   = m_len_reg;
    assign m_status         = m_stat_reg;
    assign m_last_chunk     = m_last_reg;

endmodule
